>>> hw/rtl/lvmf_pkg.sv
`timescale 1ns / 1ps
package lvmf_pkg;
    localparam int MAX_DIM = 64;
    localparam int MAX_RADIUS = 3;
    localparam int NUM_LABELS = 256;
    localparam int DIM_W = 7;
    localparam int CRD_W = $clog2(MAX_DIM);
    localparam int ADDR_W = 3 * CRD_W;
    localparam int LAB_W = 8;
    localparam int BIN_W = $clog2(NUM_LABELS);
    localparam int CNT_W = 9;
    localparam int RAD_W = 2;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_DIM_Z = 2'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_WALK, ST_DRAIN, ST_SCAN, ST_OUT
    } t_state;

    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] z;
    } t_pos;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic [CRD_W-1:0] clamp_crd(input logic signed [CRD_W+2:0] c,
                                                   input logic [DIM_W-1:0] dim);
        logic signed [CRD_W+2:0] top;
        logic [CRD_W-1:0] r;
        top = $signed({2'b00, dim}) - (CRD_W+3)'(1);
        r = c[CRD_W-1:0];
        if (c < 0) r = '0;
        if (c > top) r = top[CRD_W-1:0];
        return r;
    endfunction
endpackage

>>> hw/rtl/lvmf_if.sv
`timescale 1ns / 1ps
interface lvmf_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic [7:0] voxel_label;
    modport source (output valid, cmd, voxel_label, input ready);
    modport sink (input valid, cmd, voxel_label, output ready);
endinterface

interface lvmf_out_if;
    logic valid;
    logic ready;
    logic [7:0] out_label;
    logic last_voxel;
    modport source (output valid, out_label, last_voxel, input ready);
    modport sink (input valid, out_label, last_voxel, output ready);
endinterface

interface lvmf_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/label_volume_mode_filter.sv
`timescale 1ns / 1ps
// Mode filter over a label volume of up to 64x64x64 voxels. Load requests
// (cmd 0) write one voxel each into the internal store in x, y, z raster
// order. An emit request (cmd 1) clears a 256-bin
// histogram, walks the (2r+1)^3 clamped window one voxel per cycle through a
// single histogram read-modify-write port, then scans the bins one per cycle.
// Ties go to the lowest label. Output is meaningful only once the volume
// is loaded.
module label_volume_mode_filter (
    input logic i_clk,
    input logic i_rst_n,
    lvmf_in_if.sink  s_in,
    lvmf_out_if.source m_out,
    lvmf_cfg_if.sink s_cfg
);
    import lvmf_pkg::*;
    t_state r_state, n_state;
    logic [DIM_W-1:0] r_dx, r_dy, r_dz;
    logic [RAD_W-1:0] r_rad;
    t_pos r_ld, r_em, n_ld, r_c;
    logic signed [CRD_W+2:0] r_i, r_j, r_k;
    logic [BIN_W:0] r_bin;
    logic [LAB_W-1:0] r_mem [MAX_DIM*MAX_DIM*MAX_DIM];
    logic [LAB_W-1:0] r_rd;
    logic r_rd_v, r_rd_v2;
    logic [CNT_W-1:0] r_best_cnt;
    logic [BIN_W-1:0] r_best;
    logic r_last, r_ovalid, r_scan_v;
    logic [BIN_W-1:0] r_scan_bin;
    logic [CNT_W-1:0] w_hcnt;
    logic signed [CRD_W+2:0] w_rs;
    logic [ADDR_W-1:0] w_raddr;
    logic w_walk_end, w_em_last;
    logic [CRD_W-1:0] w_xx, w_yy, w_zz;

    assign w_rs = $signed({{(CRD_W+1){1'b0}}, r_rad});
    assign w_xx = clamp_crd($signed({3'b000, r_c.x}) + r_i, r_dx);
    assign w_yy = clamp_crd($signed({3'b000, r_c.y}) + r_j, r_dy);
    assign w_zz = clamp_crd($signed({3'b000, r_c.z}) + r_k, r_dz);
    assign w_raddr = {w_zz, w_yy, w_xx};
    assign w_walk_end = (r_i == w_rs) && (r_j == w_rs) && (r_k == w_rs);
    assign w_em_last = ({1'b0, r_em.x} == r_dx - 1) && ({1'b0, r_em.y} == r_dy - 1)
                    && ({1'b0, r_em.z} == r_dz - 1);

    assign s_in.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign s_cfg.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.out_label = r_best;
    assign m_out.last_voxel = r_last;

    lvmf_hist u_hist (
        .i_clk(i_clk),
        .i_clr_en(r_state == ST_CLEAR),
        .i_clr_addr(r_bin[BIN_W-1:0]),
        .i_inc_en(r_rd_v),
        .i_inc_addr(r_rd),
        .i_rd_addr(r_bin[BIN_W-1:0]),
        .o_rd_data(w_hcnt)
    );

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready && s_in.cmd == CMD_LOAD) begin
            r_mem[{r_ld.z, r_ld.y, r_ld.x}] <= s_in.voxel_label;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_ld = r_ld;
        if ({1'b0, r_ld.x} == r_dx - 1) begin
            n_ld.x = '0;
            if ({1'b0, r_ld.y} == r_dy - 1) begin
                n_ld.y = '0;
                if ({1'b0, r_ld.z} == r_dz - 1) n_ld.z = '0;
                else n_ld.z = r_ld.z + 1'b1;
            end else n_ld.y = r_ld.y + 1'b1;
        end else n_ld.x = r_ld.x + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_in.valid && s_in.ready && s_in.cmd == CMD_EMIT) n_state = ST_CLEAR;
            ST_CLEAR: if (r_bin == (BIN_W+1)'(NUM_LABELS-1)) n_state = ST_WALK;
            ST_WALK: if (w_walk_end) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_rd_v && !r_rd_v2) n_state = ST_SCAN;
            ST_SCAN: if (r_bin == (BIN_W+1)'(NUM_LABELS)) n_state = ST_OUT;
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dx <= DIM_W'(64); r_dy <= DIM_W'(64); r_dz <= DIM_W'(64);
            r_rad <= RAD_W'(1);
            r_ld <= '0; r_em <= '0;
            r_ovalid <= 1'b0; r_rd_v <= 1'b0; r_rd_v2 <= 1'b0; r_scan_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v <= (r_state == ST_WALK);
            r_rd_v2 <= r_rd_v;
            r_scan_v <= (r_state == ST_SCAN) && (r_bin != (BIN_W+1)'(NUM_LABELS));
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
            if (s_cfg.valid && s_cfg.ready) begin
                r_ld <= '0; r_em <= '0;
                case (s_cfg.index)
                    REG_DIM_X: r_dx <= clamp_dim(s_cfg.data);
                    REG_DIM_Y: r_dy <= clamp_dim(s_cfg.data);
                    REG_DIM_Z: r_dz <= clamp_dim(s_cfg.data);
                    REG_RADIUS: r_rad <= s_cfg.data[RAD_W-1:0];
                    default: r_rad <= r_rad;
                endcase
            end else if (s_in.valid && s_in.ready) begin
                if (s_in.cmd == CMD_LOAD) r_ld <= n_ld;
                else begin
                    r_c <= r_em;
                    r_last <= w_em_last;
                    if (w_em_last) r_em <= '0;
                    else if ({1'b0, r_em.x} != r_dx - 1) r_em.x <= r_em.x + 1'b1;
                    else begin
                        r_em.x <= '0;
                        if ({1'b0, r_em.y} != r_dy - 1) r_em.y <= r_em.y + 1'b1;
                        else begin
                            r_em.y <= '0;
                            r_em.z <= r_em.z + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_bin <= '0;
                r_i <= -w_rs; r_j <= -w_rs; r_k <= -w_rs;
            end
            ST_CLEAR: r_bin <= r_bin + 1'b1;
            ST_WALK: begin
                r_bin <= '0;
                if (r_i != w_rs) r_i <= r_i + (CRD_W+3)'(1);
                else begin
                    r_i <= -w_rs;
                    if (r_j != w_rs) r_j <= r_j + (CRD_W+3)'(1);
                    else begin
                        r_j <= -w_rs;
                        r_k <= r_k + (CRD_W+3)'(1);
                    end
                end
            end
            ST_DRAIN: begin
                r_bin <= '0;
                r_best_cnt <= '0;
                r_best <= '0;
            end
            ST_SCAN: r_bin <= r_bin + 1'b1;
            default: r_bin <= r_bin;
        endcase
        r_scan_bin <= r_bin[BIN_W-1:0];
        if (r_scan_v && w_hcnt > r_best_cnt) begin
            r_best_cnt <= w_hcnt;
            r_best <= r_scan_bin;
        end
    end
endmodule

>>> hw/rtl/lvmf_hist.sv
`timescale 1ns / 1ps
module lvmf_hist (
    input  logic i_clk,
    input  logic i_clr_en,
    input  logic [lvmf_pkg::BIN_W-1:0] i_clr_addr,
    input  logic i_inc_en,
    input  logic [lvmf_pkg::BIN_W-1:0] i_inc_addr,
    input  logic [lvmf_pkg::BIN_W-1:0] i_rd_addr,
    output logic [lvmf_pkg::CNT_W-1:0] o_rd_data
);
    import lvmf_pkg::*;
    logic [CNT_W-1:0] r_mem [NUM_LABELS];
    logic [CNT_W-1:0] r_inc_data;
    logic [BIN_W-1:0] r_inc_addr;
    logic r_inc_wr;
    logic [BIN_W-1:0] n_rd_addr;

    // Increment is read then write; a repeated bin forwards the pending value.
    assign n_rd_addr = i_inc_en ? i_inc_addr : i_rd_addr;

    always_ff @(posedge i_clk) begin
        if (r_inc_wr && (r_inc_addr == n_rd_addr)) begin
            o_rd_data <= r_inc_data;
        end else begin
            o_rd_data <= r_mem[n_rd_addr];
        end
        r_inc_wr <= i_inc_en;
        r_inc_addr <= i_inc_addr;
        if (i_clr_en) begin
            r_mem[i_clr_addr] <= '0;
        end else if (r_inc_wr) begin
            r_mem[r_inc_addr] <= r_inc_data;
        end
    end

    always_comb begin
        r_inc_data = o_rd_data + CNT_W'(1);
    end
endmodule

>>> hw/rtl/lvmf_checker.sv
`timescale 1ns / 1ps
module lvmf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid, i_in_ready, i_in_cmd,
    input logic i_out_valid, i_out_ready,
    input logic i_cfg_ready
);
    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd |=> !i_in_ready) else $error("busy");
    a_out_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready && !i_cfg_ready) else $error("out");
    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_cmd && !i_out_valid |=> !i_out_valid)
        else $error("load");
    a_ready_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == i_cfg_ready) else $error("rdy");
endmodule

bind label_volume_mode_filter lvmf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready), .i_in_cmd(s_in.cmd),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_cfg_ready(s_cfg.ready)
);
